>>> rtl/pcf_pkg.sv
package pcf_pkg;

  localparam int ATAN_STEPS = 24;

  localparam logic [31:0] ATAN_TURNS [ATAN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic signed [31:0] INV_CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [31:0] INITIAL_FREQ_RST = -32'sd1073918000;
  localparam logic [15:0] AFC_COEFF_RST  = 16'd1207;
  localparam logic [15:0] PHASE_GAIN_RST = 16'd655;
  localparam logic [15:0] FREQ_GAIN_RST  = 16'd419;

  localparam logic [1:0] REG_INITIAL_FREQ = 2'd0;
  localparam logic [1:0] REG_AFC_COEFF    = 2'd1;
  localparam logic [1:0] REG_PHASE_GAIN   = 2'd2;
  localparam logic [1:0] REG_FREQ_GAIN    = 2'd3;

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_ROT_INIT = 19'h00002,
    ST_ROT      = 19'h00004,
    ST_M0       = 19'h00008,
    ST_M1       = 19'h00010,
    ST_M2       = 19'h00020,
    ST_M3       = 19'h00040,
    ST_M4       = 19'h00080,
    ST_L0       = 19'h00100,
    ST_L1       = 19'h00200,
    ST_L2       = 19'h00400,
    ST_VEC_INIT = 19'h00800,
    ST_VEC      = 19'h01000,
    ST_G0       = 19'h02000,
    ST_G1       = 19'h04000,
    ST_G2       = 19'h08000,
    ST_DONE     = 19'h10000
  } state_t;

endpackage

>>> rtl/pilot_carrier_fpll.sv
// Pilot carrier frequency/phase locked loop.
// Input channel: in_valid/in_stall with in_sample_i, in_sample_q, one complex
// sample per transaction. Output channel: out_valid/out_stall with
// out_demod_out, one result per input transaction, in order.
// Each sample passes through the sin/cos rotation, the mixing products, the
// loop filter, the atan2 vectoring and the loop gains; the vectoring is
// skipped when both filter values are zero, and the next sample can be taken
// in the cycle the result shows. in_stall is high meanwhile, as one CORDIC
// unit (sin/cos rotation, then atan2 vectoring) and one multiplier are shared.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and processed, and the block waits at its last step
// until the register is free.
// Configuration via the APB port (4 registers at 0x0, 0x4, 0x8, 0xC); a write
// of initial_freq also reloads the NCO frequency. Write only while idle.
// Reset (rst_n low, synchronous) sets the registers to their defaults, the NCO
// phase and filter state to zero, and the frequency to initial_freq.
module pilot_carrier_fpll #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int PHASE_WIDTH      = 32,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_q,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_demod_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int NITER   = (ANGLE_ITERATIONS < pcf_pkg::ATAN_STEPS) ?
                           ANGLE_ITERATIONS : pcf_pkg::ATAN_STEPS;
  localparam int KW      = $clog2(NITER);
  localparam int SW      = SAMPLE_WIDTH;
  localparam int PW      = PHASE_WIDTH;
  localparam int LP_FRAC = 30 - SW;
  localparam int MA_W    = 36;
  localparam int MB_W    = ((SW > 17) ? SW : 17) + 1;
  localparam int PR_W    = MA_W + MB_W;
  localparam int AW      = PR_W + 1;
  localparam int CW      = 36;
  localparam int LPW     = 34;
  localparam int SHL     = (PW >= 32) ? PW - 32 : 0;
  localparam int SHR     = (PW >= 32) ? 0 : 32 - PW;

  function automatic logic [PW-1:0] scale_turns(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v <<< SHL) >>> SHR;
    return t[PW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW:0] v);
    if (v > $signed((AW+1)'(32'sh7FFFFFFF))) return 32'sh7FFFFFFF;
    else if (v < $signed(-(AW+1)'(33'sh080000000))) return 32'sh80000000;
    else return v[31:0];
  endfunction

  pcf_pkg::state_t state_r, state_nxt;

  logic signed [31:0] initial_freq_r;
  logic [15:0]        afc_coeff_r, phase_gain_r, freq_gain_r;
  logic [PW-1:0]      phase_r, freq_r;
  logic signed [LPW-1:0] lp_re_r, lp_im_r;
  logic signed [SW-1:0]  si_r, sq_r;
  logic signed [31:0]    s_r, c_r, xr_r, xi_r;
  logic signed [SW-1:0]  dem_r;
  logic signed [15:0]    err_r;
  logic signed [CW-1:0]  cx_r, cy_r, cz_r;
  logic [KW-1:0]         k_r;
  logic                  flip_r;
  logic signed [AW-1:0]  acc_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_demod_r;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      pcf_pkg::REG_INITIAL_FREQ: prdata = initial_freq_r;
      pcf_pkg::REG_AFC_COEFF:    prdata = {16'd0, afc_coeff_r};
      pcf_pkg::REG_PHASE_GAIN:   prdata = {16'd0, phase_gain_r};
      pcf_pkg::REG_FREQ_GAIN:    prdata = {16'd0, freq_gain_r};
      default:                   prdata = '0;
    endcase
  end

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod;
  logic signed [15:0]     err_now;
  logic signed [32:0]     ez;
  logic signed [16:0]     esh;
  logic signed [31:0]     s_now;

  assign s_now = flip_r ? -cy_r[31:0] : cy_r[31:0];

  always_comb begin
    ez  = {cz_r[31], cz_r[31:0]} + 33'sd32768;
    esh = ez[32:16];
    if (esh > 17'sd16384) err_now = 16'sd16384;
    else if (esh < -17'sd16384) err_now = -16'sd16384;
    else err_now = esh[15:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      pcf_pkg::ST_M0: begin mul_a = MA_W'(s_now); mul_b = MB_W'(si_r); end
      pcf_pkg::ST_M1: begin mul_a = MA_W'(c_r); mul_b = MB_W'(sq_r); end
      pcf_pkg::ST_M2: begin mul_a = MA_W'(c_r); mul_b = MB_W'(si_r); end
      pcf_pkg::ST_M3: begin mul_a = MA_W'(s_r); mul_b = MB_W'(sq_r); end
      pcf_pkg::ST_L0: begin
        mul_a = MA_W'(xr_r) - MA_W'(lp_re_r);
        mul_b = $signed(MB_W'(afc_coeff_r));
      end
      pcf_pkg::ST_L1: begin
        mul_a = MA_W'(xi_r) - MA_W'(lp_im_r);
        mul_b = $signed(MB_W'(afc_coeff_r));
      end
      pcf_pkg::ST_G0: begin mul_a = MA_W'(err_now); mul_b = $signed(MB_W'(phase_gain_r)); end
      pcf_pkg::ST_G1: begin mul_a = MA_W'(err_r); mul_b = $signed(MB_W'(freq_gain_r)); end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // CORDIC step, shared by rotation and vectoring
  logic signed [CW-1:0] dx, dy, atan_k;
  logic                 pos_rot;
  logic [31:0]          ptop;
  logic [PW-1:0]        phase_adv;
  logic [PW+31:0]       pcat;

  assign dx      = cy_r >>> k_r;
  assign dy      = cx_r >>> k_r;
  assign atan_k  = CW'(pcf_pkg::ATAN_TURNS[5'(k_r)]);
  assign pos_rot = (state_r == pcf_pkg::ST_VEC) ? !(cy_r > 0) : (cz_r >= 0);
  assign pcat    = {phase_r, 32'd0} >> PW;
  assign ptop    = pcat[31:0];
  assign phase_adv = phase_r + freq_r;

  // rounding of products and filter update
  logic signed [AW:0]    rsum;
  logic signed [31:0]    xsat;
  logic signed [32:0]    dsum;
  logic signed [32-LP_FRAC:0] dsh;
  logic signed [SW-1:0]  dem_now;
  logic signed [AW:0]    lsum;
  logic signed [LPW-1:0] lstep;

  always_comb begin
    rsum = {acc_r[AW-1], acc_r} + (AW+1)'(1 << (SW-1));
    xsat = sat32(rsum >>> SW);
    dsum = {xsat[31], xsat} + 33'(1 << (LP_FRAC-1));
    dsh  = dsum[32:LP_FRAC];
    if (dsh > $signed((33-LP_FRAC)'((1 << (SW-1)) - 1)))
      dem_now = {1'b0, {(SW-1){1'b1}}};
    else if (dsh < -$signed((33-LP_FRAC)'(1 << (SW-1))))
      dem_now = {1'b1, {(SW-1){1'b0}}};
    else
      dem_now = dsh[SW-1:0];
    lsum  = {acc_r[AW-1], acc_r} + (AW+1)'(32768);
    lstep = LPW'(lsum >>> 16);
  end

  logic signed [63:0] acc64;
  assign acc64 = 64'(acc_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcf_pkg::ST_IDLE:     if (in_valid) state_nxt = pcf_pkg::ST_ROT_INIT;
      pcf_pkg::ST_ROT_INIT: state_nxt = pcf_pkg::ST_ROT;
      pcf_pkg::ST_ROT:      if (k_r == KW'(NITER-1)) state_nxt = pcf_pkg::ST_M0;
      pcf_pkg::ST_M0:       state_nxt = pcf_pkg::ST_M1;
      pcf_pkg::ST_M1:       state_nxt = pcf_pkg::ST_M2;
      pcf_pkg::ST_M2:       state_nxt = pcf_pkg::ST_M3;
      pcf_pkg::ST_M3:       state_nxt = pcf_pkg::ST_M4;
      pcf_pkg::ST_M4:       state_nxt = pcf_pkg::ST_L0;
      pcf_pkg::ST_L0:       state_nxt = pcf_pkg::ST_L1;
      pcf_pkg::ST_L1:       state_nxt = pcf_pkg::ST_L2;
      pcf_pkg::ST_L2:       state_nxt = pcf_pkg::ST_VEC_INIT;
      pcf_pkg::ST_VEC_INIT: state_nxt = (lp_re_r == 0 && lp_im_r == 0) ?
                                        pcf_pkg::ST_G0 : pcf_pkg::ST_VEC;
      pcf_pkg::ST_VEC:      if (k_r == KW'(NITER-1)) state_nxt = pcf_pkg::ST_G0;
      pcf_pkg::ST_G0:       state_nxt = pcf_pkg::ST_G1;
      pcf_pkg::ST_G1:       state_nxt = pcf_pkg::ST_G2;
      pcf_pkg::ST_G2:       state_nxt = pcf_pkg::ST_DONE;
      pcf_pkg::ST_DONE:     if (!out_valid_r || !out_stall) state_nxt = pcf_pkg::ST_IDLE;
      default:              state_nxt = pcf_pkg::ST_IDLE;
    endcase
  end

  assign in_stall      = (state_r != pcf_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_demod_out = out_demod_r;

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pcf_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      initial_freq_r <= pcf_pkg::INITIAL_FREQ_RST;
      afc_coeff_r    <= pcf_pkg::AFC_COEFF_RST;
      phase_gain_r   <= pcf_pkg::PHASE_GAIN_RST;
      freq_gain_r    <= pcf_pkg::FREQ_GAIN_RST;
      phase_r        <= '0;
      freq_r         <= scale_turns(64'(pcf_pkg::INITIAL_FREQ_RST));
      lp_re_r        <= '0;
      lp_im_r        <= '0;
      k_r            <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pcf_pkg::ST_DONE && (!out_valid_r || !out_stall))
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          pcf_pkg::REG_INITIAL_FREQ: begin
            initial_freq_r <= pwdata;
            freq_r         <= scale_turns(64'($signed(pwdata)));
          end
          pcf_pkg::REG_AFC_COEFF:  afc_coeff_r  <= pwdata[15:0];
          pcf_pkg::REG_PHASE_GAIN: phase_gain_r <= pwdata[15:0];
          pcf_pkg::REG_FREQ_GAIN:  freq_gain_r  <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        pcf_pkg::ST_IDLE: if (in_valid) phase_r <= phase_adv;
        pcf_pkg::ST_ROT, pcf_pkg::ST_VEC: k_r <= k_r + 1'b1;
        pcf_pkg::ST_ROT_INIT, pcf_pkg::ST_VEC_INIT: k_r <= '0;
        pcf_pkg::ST_L1: lp_re_r <= lp_re_r + lstep;
        pcf_pkg::ST_L2: lp_im_r <= lp_im_r + lstep;
        pcf_pkg::ST_G1: phase_r <= phase_r + scale_turns(acc64);
        pcf_pkg::ST_G2: freq_r  <= freq_r + scale_turns(acc64 >>> 8);
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pcf_pkg::ST_IDLE: begin
        si_r <= in_sample_i;
        sq_r <= in_sample_q;
      end
      pcf_pkg::ST_ROT_INIT: begin
        flip_r <= ptop[31] ^ ptop[30];
        cx_r   <= CW'(pcf_pkg::INV_CORDIC_GAIN);
        cy_r   <= '0;
        cz_r   <= CW'($signed({ptop[31] ^ (ptop[31] ^ ptop[30]), ptop[30:0]}));
      end
      pcf_pkg::ST_ROT, pcf_pkg::ST_VEC: begin
        if (pos_rot) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_k;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_k;
        end
      end
      pcf_pkg::ST_M0: begin
        s_r   <= flip_r ? -cy_r[31:0] : cy_r[31:0];
        c_r   <= flip_r ? -cx_r[31:0] : cx_r[31:0];
      end
      default: ;
    endcase
    case (state_r)
      pcf_pkg::ST_M0: acc_r <= acc_r + AW'(prod);
      pcf_pkg::ST_M1: acc_r <= (acc_r - AW'(prod));
      pcf_pkg::ST_M2: begin
        xr_r  <= xsat;
        dem_r <= dem_now;
        acc_r <= AW'(prod);
      end
      pcf_pkg::ST_M3: acc_r <= acc_r + AW'(prod);
      pcf_pkg::ST_M4: xi_r <= xsat;
      pcf_pkg::ST_L0, pcf_pkg::ST_L1, pcf_pkg::ST_G1: acc_r <= AW'(prod);
      pcf_pkg::ST_G0: begin
        err_r <= err_now;
        acc_r <= AW'(prod);
      end
      pcf_pkg::ST_VEC_INIT: begin
        if (lp_re_r < 0) begin
          cx_r <= -CW'(lp_re_r);
          cy_r <= -CW'(lp_im_r);
          cz_r <= CW'(64'sd2147483648);
        end else begin
          cx_r <= CW'(lp_re_r);
          cy_r <= CW'(lp_im_r);
          cz_r <= '0;
        end
      end
      default: ;
    endcase
    if (state_r == pcf_pkg::ST_ROT && k_r == KW'(NITER-1)) begin
      acc_r <= '0;
    end
    if (state_r == pcf_pkg::ST_DONE && (!out_valid_r || !out_stall))
      out_demod_r <= dem_r;
  end

endmodule
